[rtl/core/pads_pkg.sv]
package pads_pkg;

	localparam int DATA_W      = 32;
	localparam int FRAC_BITS   = 24;
	localparam int IDX_W       = 12;
	localparam int MAX_COLUMNS = 4096;
	localparam int MAX_ROWS    = 4096;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int SINE_DEPTH  = 1024;
	localparam int TAB_BITS    = $clog2(SINE_DEPTH);
	localparam int QUAD_BITS   = TAB_BITS - 2;
	localparam int QUAD_DEPTH  = SINE_DEPTH / 4;
	localparam int TRIG_W      = FRAC_BITS + 2;
	localparam int MUL_W       = DATA_W + 1;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int ACC_W       = PROD_W + 1;
	localparam int CFG_W       = 3;
	localparam int OUT_TDATA_W = DATA_W + 2 * IDX_W;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint          ONE_Q30     = 64'd1073741824;
	localparam longint unsigned SIN_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};
	localparam longint unsigned COS_DIV [8] = '{2, 12, 30, 56, 90, 132, 182, 240};

	typedef enum logic [CFG_W-1:0] {
		CFG_CENTER,
		CFG_NEIGHBOUR,
		CFG_FLUX,
		CFG_KCOS,
		CFG_KSIN,
		CFG_PHASE_STEP,
		CFG_LOW_FREQ,
		CFG_FREQ_STEP
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CPL_A,
		ST_CPL_B,
		ST_CPL_W,
		ST_CPL_ST,
		ST_FA,
		ST_FB,
		ST_FW,
		ST_FST,
		ST_C2,
		ST_C3,
		ST_RW,
		ST_EMIT,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		MS_CPL_COS,
		MS_CPL_SIN,
		MS_NEXT,
		MS_PREV,
		MS_CENTER,
		MS_SUM,
		MS_FLUX
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [1:0] {
		RK_MID,
		RK_LAST,
		RK_WRAP,
		RK_SINGLE
	} res_kind_t;

	typedef struct packed {
		logic      accept;
		mul_sel_t  mul_sel;
		acc_op_t   acc_op;
		logic      rnd;
		logic      store_cpl;
		logic      store_flux;
		logic      emit;
		logic      finish;
		res_kind_t kind;
		logic      run_last;
	} cmd_t;

	typedef struct packed {
		logic j_zero;
		logic j_one;
		logic row_end;
		logic out_free;
	} status_t;

	typedef logic [FRAC_BITS:0] trig_tab_t [QUAD_DEPTH];

	function automatic logic [FRAC_BITS:0] q30_to_fb(longint v);
		longint c;
		c = v;
		if (c < 0) c = 0;
		if (c > ONE_Q30) c = ONE_Q30;
		if (FRAC_BITS == 30) return (FRAC_BITS+1)'(c);
		return (FRAC_BITS+1)'((c + (longint'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
	endfunction

	function automatic trig_tab_t build_tab(bit want_cos);
		trig_tab_t t;
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint s;
		longint c;
		for (int i = 0; i < QUAD_DEPTH; i++) begin
			r = longint'(i) << (32 - TAB_BITS);
			x = (r * HALF_PI_Q30) >> 30;
			x2 = (x * x) >> 30;
			term = x;
			s = longint'(x);
			for (int n = 0; n < 7; n++) begin
				term = ((term * x2) >> 30) / SIN_DIV[n];
				if ((n & 1) == 0) s = s - longint'(term);
				else s = s + longint'(term);
			end
			term = longint'(ONE_Q30);
			c = ONE_Q30;
			for (int n = 0; n < 8; n++) begin
				term = ((term * x2) >> 30) / COS_DIV[n];
				if ((n & 1) == 0) c = c - longint'(term);
				else c = c + longint'(term);
			end
			t[i] = want_cos ? q30_to_fb(c) : q30_to_fb(s);
		end
		return t;
	endfunction

	localparam trig_tab_t SIN_TAB = build_tab(1'b0);
	localparam trig_tab_t COS_TAB = build_tab(1'b1);

	function automatic logic signed [DATA_W-1:0] sat32(logic signed [ACC_W-1:0] v);
		if (v[ACC_W-1:DATA_W-1] == '0 || v[ACC_W-1:DATA_W-1] == '1) return v[DATA_W-1:0];
		return v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

	function automatic logic signed [ACC_W-1:0] round_fb(logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] t;
		t = v + (ACC_W'(1) <<< (FRAC_BITS - 1));
		return t >>> FRAC_BITS;
	endfunction

endpackage

[rtl/core/pads_ctrl.sv]
module pads_ctrl import pads_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t    state_q, state_d;
	res_kind_t kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= RK_MID;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_CPL_A;
			ST_CPL_A:  state_d = ST_CPL_B;
			ST_CPL_B:  state_d = ST_CPL_W;
			ST_CPL_W:  state_d = ST_CPL_ST;
			ST_CPL_ST: begin
				if (status.j_zero) begin
					kind_d  = RK_SINGLE;
					state_d = status.row_end ? ST_FA : ST_FINISH;
				end else if (status.j_one) begin
					kind_d  = RK_LAST;
					state_d = status.row_end ? ST_FA : ST_FINISH;
				end else begin
					kind_d  = RK_MID;
					state_d = ST_FA;
				end
			end
			ST_FA:     state_d = ST_FB;
			ST_FB:     state_d = ST_FW;
			ST_FW:     state_d = ST_FST;
			ST_FST:    state_d = ST_C2;
			ST_C2:     state_d = ST_C3;
			ST_C3:     state_d = ST_RW;
			ST_RW:     state_d = ST_EMIT;
			ST_EMIT: begin
				if (status.out_free) begin
					case (kind_q)
						RK_MID: begin
							if (status.row_end) begin
								kind_d  = RK_LAST;
								state_d = ST_FA;
							end else begin
								state_d = ST_FINISH;
							end
						end
						RK_LAST: begin
							kind_d  = RK_WRAP;
							state_d = ST_FA;
						end
						default: state_d = ST_FINISH;
					endcase
				end
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.mul_sel    = MS_CPL_COS;
		cmd.acc_op     = ACC_HOLD;
		cmd.kind       = kind_q;
		cmd.run_last   = (kind_q == RK_SINGLE) || (kind_q == RK_WRAP) ||
			((kind_q == RK_MID) && !status.row_end);
		s_tready       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			ST_CPL_A: begin
				cmd.mul_sel = MS_CPL_COS;
				cmd.acc_op  = ACC_LOAD;
			end
			ST_CPL_B: begin
				cmd.mul_sel = MS_CPL_SIN;
				cmd.acc_op  = ACC_SUB;
			end
			ST_CPL_ST: cmd.store_cpl = 1'b1;
			ST_FA: begin
				cmd.mul_sel = MS_NEXT;
				cmd.acc_op  = ACC_LOAD;
			end
			ST_FB: begin
				cmd.mul_sel = MS_PREV;
				cmd.acc_op  = ACC_SUB;
			end
			ST_FST: begin
				cmd.store_flux = 1'b1;
				cmd.mul_sel    = MS_CENTER;
				cmd.acc_op     = ACC_LOAD;
				cmd.rnd        = 1'b1;
			end
			ST_C2: begin
				cmd.mul_sel = MS_SUM;
				cmd.acc_op  = ACC_ADD;
				cmd.rnd     = 1'b1;
			end
			ST_C3: begin
				cmd.mul_sel = MS_FLUX;
				cmd.acc_op  = ACC_SUB;
				cmd.rnd     = 1'b1;
			end
			ST_EMIT:   cmd.emit = status.out_free;
			ST_FINISH: cmd.finish = 1'b1;
			default: ;
		endcase
	end

endmodule

[rtl/core/pads_dp.sv]
module pads_dp import pads_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [DATA_W-1:0]      s_tdata,
	input  logic                   s_tlast,
	input  logic [0:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast,
	output logic [0:0]             m_tuser,
	input  logic                   cfg_we,
	input  logic [CFG_W-1:0]       cfg_index,
	input  logic [DATA_W-1:0]      cfg_data,
	input  cmd_t                   cmd,
	output status_t                status
);

	logic signed [DATA_W-1:0] center_coeff_q, neighbour_coeff_q, flux_coeff_q;
	logic signed [DATA_W-1:0] kcos_q, ksin_q, low_freq_q, freq_step_q;
	logic        [DATA_W-1:0] phase_step_q;

	logic signed [DATA_W-1:0] x_q, c_q, flux_q, freq_q;
	logic                     re_q, ge_q;
	logic        [COL_W-1:0]  col_q;
	logic        [ROW_W-1:0]  row_q;
	logic        [DATA_W-1:0] phase_q;
	logic signed [DATA_W-1:0] h_smp_q [2];
	logic signed [DATA_W-1:0] h_cpl_q [2];
	logic signed [DATA_W-1:0] r_smp_q [2];
	logic signed [DATA_W-1:0] r_cpl_q [2];
	logic signed [TRIG_W-1:0] sn_q, cs_q;

	logic signed [PROD_W-1:0] prod_s1;
	acc_op_t                  op_s1;
	logic                     rnd_s1;
	logic signed [ACC_W-1:0]  acc_q;

	logic                     m_valid_q, m_last_q, m_done_q;
	logic signed [DATA_W-1:0] m_dens_q;
	logic        [IDX_W-1:0]  m_row_q, m_col_q;

	logic                     re_eff, ge_eff;
	logic        [TAB_BITS-1:0] tab_idx;
	logic        [1:0]        quad;
	logic signed [TRIG_W-1:0] ta, tb, sn_d, cs_d;
	logic signed [DATA_W-1:0] center, prev, cprev, nxt, cnext, vn, vp, sum;
	logic        [IDX_W-1:0]  col_out;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [ACC_W-1:0]  term, acc_rnd;

	assign re_eff = s_tlast | s_tuser[0] | (col_q == COL_W'(MAX_COLUMNS - 1));
	assign ge_eff = s_tuser[0] | (re_eff && (row_q == ROW_W'(MAX_ROWS - 1)));

	assign status.j_zero   = (col_q == '0);
	assign status.j_one    = (col_q == COL_W'(1));
	assign status.row_end  = re_q;
	assign status.out_free = !m_valid_q || m_tready;

	assign tab_idx = phase_q[DATA_W-1 -: TAB_BITS];
	assign quad    = tab_idx[TAB_BITS-1 -: 2];
	assign ta      = TRIG_W'(SIN_TAB[tab_idx[QUAD_BITS-1:0]]);
	assign tb      = TRIG_W'(COS_TAB[tab_idx[QUAD_BITS-1:0]]);

	always_comb begin
		case (quad)
			2'd0: begin sn_d = ta;  cs_d = tb;  end
			2'd1: begin sn_d = tb;  cs_d = -ta; end
			2'd2: begin sn_d = -ta; cs_d = -tb; end
			default: begin sn_d = -tb; cs_d = ta; end
		endcase
	end

	always_comb begin
		case (cmd.kind)
			RK_MID: begin
				center = r_smp_q[1];
				prev = r_smp_q[0]; cprev = r_cpl_q[0];
				nxt = x_q; cnext = c_q;
				col_out = IDX_W'(col_q - COL_W'(1));
			end
			RK_LAST: begin
				center = x_q;
				prev = r_smp_q[1]; cprev = r_cpl_q[1];
				nxt = h_smp_q[0]; cnext = h_cpl_q[0];
				col_out = IDX_W'(col_q);
			end
			RK_WRAP: begin
				center = h_smp_q[0];
				prev = x_q; cprev = c_q;
				nxt = h_smp_q[1]; cnext = h_cpl_q[1];
				col_out = '0;
			end
			default: begin
				center = x_q;
				prev = x_q; cprev = c_q;
				nxt = x_q; cnext = c_q;
				col_out = '0;
			end
		endcase
	end

	assign vn  = sat32(ACC_W'(cnext) + ACC_W'(freq_q));
	assign vp  = sat32(ACC_W'(cprev) + ACC_W'(freq_q));
	assign sum = sat32(ACC_W'(nxt) + ACC_W'(prev));

	always_comb begin
		case (cmd.mul_sel)
			MS_CPL_COS: begin mul_a = MUL_W'(ksin_q);            mul_b = MUL_W'(cs_q);   end
			MS_CPL_SIN: begin mul_a = MUL_W'(kcos_q);            mul_b = MUL_W'(sn_q);   end
			MS_NEXT:    begin mul_a = MUL_W'(nxt);               mul_b = MUL_W'(vn);     end
			MS_PREV:    begin mul_a = MUL_W'(prev);              mul_b = MUL_W'(vp);     end
			MS_CENTER:  begin mul_a = MUL_W'(center);            mul_b = MUL_W'(center_coeff_q); end
			MS_SUM:     begin mul_a = MUL_W'(neighbour_coeff_q); mul_b = MUL_W'(sum);    end
			default:    begin mul_a = MUL_W'(flux_coeff_q);      mul_b = MUL_W'(flux_q); end
		endcase
	end

	assign term    = rnd_s1 ? round_fb(ACC_W'(prod_s1)) : ACC_W'(prod_s1);
	assign acc_rnd = round_fb(acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1  <= ACC_HOLD;
			rnd_s1 <= 1'b0;
		end else begin
			op_s1  <= cmd.acc_op;
			rnd_s1 <= cmd.rnd;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		sn_q    <= sn_d;
		cs_q    <= cs_d;
		case (op_s1)
			ACC_LOAD: acc_q <= term;
			ACC_ADD:  acc_q <= acc_q + term;
			ACC_SUB:  acc_q <= acc_q - term;
			default:  acc_q <= acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_coeff_q    <= DATA_W'(1) <<< FRAC_BITS;
			neighbour_coeff_q <= '0;
			flux_coeff_q      <= '0;
			kcos_q            <= '0;
			ksin_q            <= '0;
			phase_step_q      <= '0;
			low_freq_q        <= '0;
			freq_step_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CENTER:     center_coeff_q    <= cfg_data;
				CFG_NEIGHBOUR:  neighbour_coeff_q <= cfg_data;
				CFG_FLUX:       flux_coeff_q      <= cfg_data;
				CFG_KCOS:       kcos_q            <= cfg_data;
				CFG_KSIN:       ksin_q            <= cfg_data;
				CFG_PHASE_STEP: phase_step_q      <= cfg_data;
				CFG_LOW_FREQ:   low_freq_q        <= cfg_data;
				CFG_FREQ_STEP:  freq_step_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			phase_q <= '0;
			freq_q  <= '0;
			re_q    <= 1'b0;
			ge_q    <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				h_smp_q[i] <= '0;
				h_cpl_q[i] <= '0;
				r_smp_q[i] <= '0;
				r_cpl_q[i] <= '0;
			end
		end else begin
			if (cmd.accept) begin
				re_q <= re_eff;
				ge_q <= ge_eff;
				if (col_q == '0) h_smp_q[0] <= s_tdata;
				if (col_q == COL_W'(1)) h_smp_q[1] <= s_tdata;
				if (col_q == '0 && row_q == '0) freq_q <= low_freq_q;
			end
			if (cmd.store_cpl) begin
				if (col_q == '0) h_cpl_q[0] <= sat32(acc_rnd);
				if (col_q == COL_W'(1)) h_cpl_q[1] <= sat32(acc_rnd);
			end
			if (cmd.finish) begin
				r_smp_q[0] <= r_smp_q[1];
				r_cpl_q[0] <= r_cpl_q[1];
				r_smp_q[1] <= x_q;
				r_cpl_q[1] <= c_q;
				if (re_q) begin
					col_q   <= '0;
					phase_q <= '0;
					if (ge_q) begin
						row_q  <= '0;
						freq_q <= low_freq_q;
					end else begin
						row_q  <= row_q + ROW_W'(1);
						freq_q <= sat32(ACC_W'(freq_q) + ACC_W'(freq_step_q));
					end
				end else begin
					col_q   <= col_q + COL_W'(1);
					phase_q <= phase_q + phase_step_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) x_q <= s_tdata;
		if (cmd.store_cpl) c_q <= sat32(acc_rnd);
		if (cmd.store_flux) flux_q <= sat32(acc_rnd);
		if (cmd.emit) begin
			m_dens_q <= sat32(acc_q);
			m_row_q  <= IDX_W'(row_q);
			m_col_q  <= col_out;
			m_last_q <= cmd.run_last;
			m_done_q <= cmd.run_last & ge_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = {m_col_q, m_row_q, m_dens_q};
	assign m_tlast    = m_last_q;
	assign m_tuser[0] = m_done_q;

endmodule

[rtl/core/periodic_advection_diffusion_stencil.sv]
// Channel      Direction  Payload
// s_*          in         tdata: density[31:0]; tlast: row_end; tuser: grid_end
// m_*          out        tdata: new_density, row_number, column_number; tlast: run_last;
//                         tuser: grid_done
// cfg_*        in         write enable, register index, 32-bit data
// One item at a time, with up to 3 results per item, each of which may wait on m_tready.
// The single shared 33x33 multiplier serves every product.
// Reset clears control, config, counters and history; working data registers are not reset.
// A stalled output holds the controller in its emit step; no input is taken meanwhile.
module periodic_advection_diffusion_stencil import pads_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [DATA_W-1:0]      s_tdata,   // density
	input  logic                   s_tlast,
	input  logic [0:0]             s_tuser,   // grid_end
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // new_density, row_number, column_number
	output logic                   m_tlast,
	output logic [0:0]             m_tuser,   // grid_done
	input  logic                   cfg_we,
	input  logic [CFG_W-1:0]       cfg_index,
	input  logic [DATA_W-1:0]      cfg_data
);

	cmd_t    cmd;
	status_t status;

	pads_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pads_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

[rtl/core/pads_chk.sv]
module pads_chk import pads_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tlast,
	input logic [0:0]             m_tuser
);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("grid end on an item that is not last");

	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !s_tready)
		else $error("result appeared while idle");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output item changed");

endmodule

bind periodic_advection_diffusion_stencil pads_chk u_pads_chk (.*);

[bench/periodic_advection_diffusion_stencil_tb.sv]
module periodic_advection_diffusion_stencil_tb;
	import pads_pkg::*;

	typedef logic signed [79:0] wide_t;

	typedef struct {
		logic [31:0] density;
		logic        row_end;
		logic        grid_end;
	} sample_t;

	typedef struct {
		logic [31:0] new_density;
		logic [11:0] row_number;
		logic [11:0] column_number;
		logic        run_last;
		logic        grid_done;
	} update_t;

	localparam int STALL_LIMIT = 5000;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [DATA_W-1:0]      s_tdata;
	logic                   s_tlast;
	logic [0:0]             s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic [0:0]             m_tuser;
	logic                   cfg_we;
	logic [CFG_W-1:0]       cfg_index;
	logic [DATA_W-1:0]      cfg_data;

	periodic_advection_diffusion_stencil uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tlast(s_tlast), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	sample_t pending_samples[$];
	update_t expected_updates[$];

	// stencil state mirrored from the block
	logic signed [31:0] weights[8];
	logic signed [31:0] head_density[2], head_cpl[2], last_density[2], last_cpl[2];
	logic [31:0]        col_cnt, row_cnt;
	logic [31:0]        phase_acc;
	logic signed [31:0] row_freq;

	int  samples_in, updates_out, errors, stall_cycles;
	bit  in_taken, no_idle, send_enable;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [31:0] clamp32(wide_t v);
		if (v > 80'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -80'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic wide_t round_q24(wide_t v);
		return (v + (80'sd1 <<< 23)) >>> 24;
	endfunction

	function automatic longint trig_to_q24(longint v);
		if (v < 0) v = 0;
		if (v > 64'd1073741824) v = 64'd1073741824;
		return (v + 32) >>> 6;
	endfunction

	function automatic logic signed [31:0] coupling_at(logic [31:0] ph);
		longint unsigned idx, u, r, x, x2, term;
		longint s, c, a, b, sn, cs;
		wide_t ks, kc, acc;
		idx = ({32'b0, ph} * 64'd1024) >> 32;
		u = ((idx << 32) / 64'd1024) & 64'hFFFFFFFF;
		r = u & 64'h3FFFFFFF;
		x = (r * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		term = x;
		s = x;
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
			if (n % 2 == 1) s = s - longint'(term);
			else s = s + longint'(term);
		end
		term = 64'd1073741824;
		c = 64'd1073741824;
		for (int n = 1; n <= 8; n++) begin
			term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
			if (n % 2 == 1) c = c - longint'(term);
			else c = c + longint'(term);
		end
		a = trig_to_q24(s);
		b = trig_to_q24(c);
		case (u >> 30)
			0: begin sn = a;  cs = b;  end
			1: begin sn = b;  cs = -a; end
			2: begin sn = -a; cs = -b; end
			default: begin sn = -b; cs = a; end
		endcase
		ks = weights[CFG_KSIN];
		kc = weights[CFG_KCOS];
		acc = ks * wide_t'(cs) - kc * wide_t'(sn);
		return clamp32(round_q24(acc));
	endfunction

	function automatic logic signed [31:0] stencil(logic signed [31:0] center,
			logic signed [31:0] prev, logic signed [31:0] cprev,
			logic signed [31:0] nxt, logic signed [31:0] cnext);
		wide_t w, vn, vp, fl, sm, c1, c2, c3;
		w = row_freq;
		vn = clamp32(wide_t'(cnext) + w);
		vp = clamp32(wide_t'(cprev) + w);
		fl = clamp32(round_q24(wide_t'(nxt) * vn - wide_t'(prev) * vp));
		sm = clamp32(wide_t'(nxt) + wide_t'(prev));
		c1 = weights[CFG_CENTER];
		c2 = weights[CFG_NEIGHBOUR];
		c3 = weights[CFG_FLUX];
		return clamp32(round_q24(wide_t'(center) * c1) + round_q24(c2 * sm)
			- round_q24(c3 * fl));
	endfunction

	task automatic queue_update(logic signed [31:0] v, logic [31:0] r, logic [31:0] c);
		update_t e;
		e.new_density = v;
		e.row_number = r[11:0];
		e.column_number = c[11:0];
		e.run_last = 1'b0;
		e.grid_done = 1'b0;
		expected_updates.push_back(e);
	endtask

	task automatic advance_stencil(sample_t it);
		logic signed [31:0] x, c;
		logic [31:0] j, row;
		bit re, ge;
		int n;
		x = it.density;
		ge = it.grid_end;
		re = it.row_end || ge;
		j = col_cnt;
		row = row_cnt;
		n = 0;
		if (j >= MAX_COLUMNS - 1) re = 1;
		if (re && row >= MAX_ROWS - 1) ge = 1;
		if (j == 0 && row == 0) row_freq = weights[CFG_LOW_FREQ];
		c = coupling_at(phase_acc);
		if (j == 0) begin
			head_density[0] = x;
			head_cpl[0] = c;
			if (re) begin
				queue_update(stencil(x, x, c, x, c), row, 0);
				n++;
			end
		end else begin
			if (j == 1) begin
				head_density[1] = x;
				head_cpl[1] = c;
			end
			if (j >= 2) begin
				queue_update(stencil(last_density[1], last_density[0], last_cpl[0], x, c),
					row, j - 1);
				n++;
			end
			if (re) begin
				queue_update(stencil(x, last_density[1], last_cpl[1], head_density[0],
					head_cpl[0]), row, j);
				queue_update(stencil(head_density[0], x, c, head_density[1], head_cpl[1]),
					row, 0);
				n += 2;
			end
		end
		last_density[0] = last_density[1];
		last_cpl[0] = last_cpl[1];
		last_density[1] = x;
		last_cpl[1] = c;
		if (n > 0) begin
			expected_updates[$].run_last = 1'b1;
			expected_updates[$].grid_done = ge;
		end
		if (re) begin
			col_cnt = 0;
			phase_acc = 0;
			if (ge) begin
				row_cnt = 0;
				row_freq = weights[CFG_LOW_FREQ];
			end else begin
				row_cnt = row + 1;
				row_freq = clamp32(wide_t'(row_freq) + wide_t'(weights[CFG_FREQ_STEP]));
			end
		end else begin
			col_cnt = j + 1;
			phase_acc = phase_acc + weights[CFG_PHASE_STEP];
		end
	endtask

	// check results, then predict from accepted items
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				update_t e;
				updates_out++;
				if (expected_updates.size() == 0) begin
					$error("unexpected result item %h", m_tdata);
					errors++;
				end else begin
					e = expected_updates.pop_front();
					if (m_tdata[31:0] !== e.new_density) begin
						$error("new_density expected %h got %h", e.new_density, m_tdata[31:0]);
						errors++;
					end
					if (m_tdata[43:32] !== e.row_number) begin
						$error("row_number expected %0d got %0d", e.row_number, m_tdata[43:32]);
						errors++;
					end
					if (m_tdata[55:44] !== e.column_number) begin
						$error("column_number expected %0d got %0d", e.column_number,
							m_tdata[55:44]);
						errors++;
					end
					if (m_tlast !== e.run_last) begin
						$error("run_last expected %b got %b", e.run_last, m_tlast);
						errors++;
					end
					if (m_tuser[0] !== e.grid_done) begin
						$error("grid_done expected %b got %b", e.grid_done, m_tuser[0]);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				sample_t it;
				it.density = s_tdata;
				it.row_end = s_tlast;
				it.grid_end = s_tuser[0];
				advance_stencil(it);
				samples_in++;
				in_taken <= 1'b1;
			end else begin
				in_taken <= 1'b0;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// sender
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !in_taken) begin
				s_tvalid <= 1'b1;
			end else if (send_enable && pending_samples.size() > 0 &&
					(no_idle || $urandom_range(0, 99) >= 33)) begin
				sample_t it;
				it = pending_samples.pop_front();
				s_tdata <= it.density;
				s_tlast <= it.row_end;
				s_tuser <= it.grid_end;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
			m_tready <= no_idle || $urandom_range(0, 99) >= 33;
		end
	end

	task automatic push_sample(logic [31:0] d, bit re, bit ge);
		sample_t it;
		it.density = d;
		it.row_end = re;
		it.grid_end = ge;
		pending_samples.push_back(it);
	endtask

	function automatic logic [31:0] pick_density();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(0, 32'h03000000);
			3: return -$urandom_range(0, 32'h03000000);
			default: return $urandom;
		endcase
	endfunction

	task automatic push_row(int len, bit ge);
		for (int i = 0; i < len; i++)
			push_sample(pick_density(), i == len - 1, ge && i == len - 1);
	endtask

	task automatic drain();
		send_enable = 1'b1;
		do @(negedge clk);
		while (pending_samples.size() > 0 || s_tvalid || expected_updates.size() > 0);
		send_enable = 1'b0;
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		weights[idx] = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(logic [31:0] c1, logic [31:0] c2, logic [31:0] c3,
			logic [31:0] kc, logic [31:0] ks, logic [31:0] ps,
			logic [31:0] lf, logic [31:0] fs);
		write_reg(CFG_CENTER, c1);
		write_reg(CFG_NEIGHBOUR, c2);
		write_reg(CFG_FLUX, c3);
		write_reg(CFG_KCOS, kc);
		write_reg(CFG_KSIN, ks);
		write_reg(CFG_PHASE_STEP, ps);
		write_reg(CFG_LOW_FREQ, lf);
		write_reg(CFG_FREQ_STEP, fs);
	endtask

	task automatic random_rows(int count);
		int len;
		for (int i = 0; i < count; ) begin
			if ($urandom_range(0, 9) < 8) begin
				len = $urandom_range(0, 4) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 9);
				push_row(len, $urandom_range(0, 5) == 0);
				i += len;
			end else begin
				push_sample($urandom, $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
				i++;
			end
		end
	endtask

	function automatic logic [31:0] small_coeff();
		return $urandom_range(0, 32'h02000000) - 32'h01000000;
	endfunction

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_CENTER;
		cfg_data = '0;
		in_taken = 1'b0;
		no_idle = 1'b0;
		send_enable = 1'b0;
		samples_in = 0;
		updates_out = 0;
		errors = 0;
		stall_cycles = 0;
		foreach (weights[i]) weights[i] = '0;
		weights[CFG_CENTER] = 32'sh01000000;
		foreach (head_density[i]) begin
			head_density[i] = '0;
			head_cpl[i] = '0;
			last_density[i] = '0;
			last_cpl[i] = '0;
		end
		col_cnt = 0;
		row_cnt = 0;
		phase_acc = 0;
		row_freq = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// reset weights: plain pass of the center sample
		push_row(1, 0);
		push_row(2, 0);
		push_row(3, 1);
		drain();

		write_all(small_coeff(), small_coeff(), small_coeff(), small_coeff(), small_coeff(),
			32'h0D000000, 32'h00800000, 32'hFFC00000);
		push_sample(32'h7FFFFFFF, 0, 0);
		push_sample(32'h80000000, 0, 0);
		push_sample(32'h00000000, 0, 0);
		push_sample(32'hFFFFFFFF, 0, 1);
		push_sample(32'h01000000, 1, 0);
		push_sample(32'h80000000, 0, 0);
		push_sample(32'h7FFFFFFF, 1, 0);
		push_row(4, 1);
		drain();

		write_all(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		push_row(3, 0);
		push_row(5, 0);
		push_row(2, 1);
		drain();

		write_all(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h00000000, 32'h80000000, 32'h80000000);
		push_row(4, 0);
		push_row(1, 0);
		push_row(3, 1);
		drain();

		for (int p = 0; p < 4; p++) begin
			write_all(small_coeff(), small_coeff(), small_coeff(), small_coeff(), small_coeff(),
				$urandom, small_coeff(), small_coeff());
			if (p == 2) no_idle = 1'b1;
			random_rows(20);
			drain();
			no_idle = 1'b0;
		end

		$display("covered %0d density items and %0d updates over several weight sets,",
			samples_in, updates_out);
		$display("short and wrapped rows, saturating weights and grid ends without row ends");
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule
